[rtl/assert_macros.svh]
// Assertion macros for the radix trie map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTKV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rtkv assertion failed");
`define RTKV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtkv implication failed");
`else
`define RTKV_ASSERT(label, clk, rst_n, prop)
`define RTKV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/rtkv_pkg.sv]
// Types and constants of the radix trie key/value map.
package rtkv_pkg;

    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 16;
    localparam int CMD_BITS   = 2;

    localparam logic [VALUE_BITS-1:0] VALUE_EMPTY  = '1;
    localparam logic [KEY_BITS-1:0]   KEY_ALL_ONES = '1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LINK,
        S_META,
        S_CHECK,
        S_COUNT,
        S_ROOM,
        S_ALLOC,
        S_FINISH,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [CMD_BITS-1:0]   command;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_BITS-1:0] result_value;
        logic                  found;
        logic                  pool_full;
    } t_out_word;

endpackage

[rtl/radix_trie_key_value_map.sv]
// Top level of the radix trie key/value map: sequencer, trie walk and node pool.
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (command, key, value)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (result_value, found,
//          |           |                          |             pool_full)
//
// Per word: accept in S_IDLE, then per level link read, tag read, tag check (S_LINK,
// S_META, S_CHECK). A hit or an empty key ends in S_FINISH; a find or delete miss,
// a bad command or a find of the all-ones key go to S_RESP. An insert off the path
// counts missing digits, tests room, adds nodes (S_ALLOC); S_RESP loads the output.
// Reset is synchronous and clears sequencer, node count and root value; stale links
// fail the owner tag check. A full output register holds the next result in S_RESP.
module radix_trie_key_value_map #(
    parameter int DIGIT_BITS = 4,
    parameter int NODE_COUNT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rtkv_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rtkv_pkg::t_out_word o_out_data
);
    import rtkv_pkg::*;

    `include "assert_macros.svh"

    // Sizes of the node pool and its memories.
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LINK_DEPTH = NODE_COUNT * (2 ** DIGIT_BITS);
    localparam int LINK_AW    = IDX_W + DIGIT_BITS;
    localparam int MAX_DIGITS = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int NEED_W     = $clog2(MAX_DIGITS + 1);
    localparam int META_W     = IDX_W + DIGIT_BITS + VALUE_BITS;

    // Per-node record: the link that owns the node, and its value.
    typedef struct packed {
        logic [IDX_W-1:0]      parent;
        logic [DIGIT_BITS-1:0] digit;
        logic [VALUE_BITS-1:0] value;
    } t_meta;

    // Sequencer and walk registers.
    t_state                r_state, n_state;
    logic [CMD_BITS-1:0]   r_cmd, n_cmd;
    logic [KEY_BITS-1:0]   r_rest, n_rest;
    logic [KEY_BITS-1:0]   r_scan, n_scan;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [IDX_W-1:0]      r_node, n_node;
    logic [IDX_W-1:0]      r_par, n_par;
    logic [DIGIT_BITS-1:0] r_dig, n_dig;
    logic [VALUE_BITS-1:0] r_cur_val, n_cur_val;
    logic [IDX_W-1:0]      r_child, n_child;
    logic [NEED_W-1:0]     r_need, n_need;
    logic [CNT_W-1:0]      r_nodes_used, n_nodes_used;
    logic [VALUE_BITS-1:0] r_root_val, n_root_val;
    t_out_word             r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out_data, n_out_data;

    // Memory ports.
    logic                  link_rd_en, link_wr_en;
    logic [LINK_AW-1:0]    link_rd_addr, link_wr_addr;
    logic [IDX_W-1:0]      link_wr_data, link_rd_data;
    logic                  meta_rd_en, meta_wr_en;
    logic [IDX_W-1:0]      meta_rd_addr, meta_wr_addr;
    t_meta                 meta_wr_data;
    logic [META_W-1:0]     meta_rd_raw;
    t_meta                 w_meta;

    // Shared datapath terms.
    logic [DIGIT_BITS-1:0] w_digit;
    logic [KEY_BITS-1:0]   w_rest_next;
    logic                  w_last;
    logic                  w_link_ok;
    logic [CNT_W:0]        w_need_total;
    logic                  w_room;
    logic                  w_out_free;
    logic [VALUE_BITS-1:0] w_node_val;
    logic                  w_cmd_valid;

    assign w_digit      = r_rest[DIGIT_BITS-1:0];
    assign w_rest_next  = r_rest >> DIGIT_BITS;
    assign w_last       = (w_rest_next == '0);
    assign w_meta       = t_meta'(meta_rd_raw);
    // Follow a link only if it names an allocated node owned by this slot.
    assign w_link_ok    = (r_child != '0)
                       && ({1'b0, r_child} < r_nodes_used)
                       && (w_meta.parent == r_node)
                       && (w_meta.digit == w_digit);
    assign w_need_total = {1'b0, r_nodes_used} + (CNT_W + 1)'(r_need);
    assign w_room       = (w_need_total <= (CNT_W + 1)'(NODE_COUNT));
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_node_val   = (r_node == '0) ? r_root_val : r_cur_val;
    assign w_cmd_valid  = i_in_data.command inside {CMD_INSERT, CMD_DELETE, CMD_FIND};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Child links: one entry per node and digit.
    rtkv_ram #(
        .WIDTH (IDX_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data),
        .i_rd_en   (link_rd_en),
        .i_rd_addr (link_rd_addr),
        .o_rd_data (link_rd_data)
    );

    // Node records: owner tag and stored value.
    rtkv_ram #(
        .WIDTH (META_W),
        .DEPTH (NODE_COUNT)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (meta_wr_en),
        .i_wr_addr (meta_wr_addr),
        .i_wr_data (META_W'(meta_wr_data)),
        .i_rd_en   (meta_rd_en),
        .i_rd_addr (meta_rd_addr),
        .o_rd_data (meta_rd_raw)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!w_cmd_valid) begin
                        n_state = S_RESP;
                    end else if ((i_in_data.command == CMD_FIND)
                                 && (i_in_data.key == KEY_ALL_ONES)) begin
                        n_state = S_RESP;
                    end else if (i_in_data.key == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_LINK;
                    end
                end
            end
            S_LINK:  n_state = S_META;
            S_META:  n_state = S_CHECK;
            S_CHECK: begin
                if (w_link_ok) begin
                    n_state = w_last ? S_FINISH : S_LINK;
                end else if (r_cmd == CMD_INSERT) begin
                    n_state = S_COUNT;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_COUNT: begin
                if (r_scan == '0) begin
                    n_state = S_ROOM;
                end
            end
            S_ROOM:   n_state = w_room ? S_ALLOC : S_RESP;
            S_ALLOC: begin
                if (w_last) begin
                    n_state = S_RESP;
                end
            end
            S_FINISH: n_state = S_RESP;
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and output register.
    always_comb begin
        n_cmd        = r_cmd;
        n_rest       = r_rest;
        n_scan       = r_scan;
        n_value      = r_value;
        n_node       = r_node;
        n_par        = r_par;
        n_dig        = r_dig;
        n_cur_val    = r_cur_val;
        n_child      = r_child;
        n_need       = r_need;
        n_nodes_used = r_nodes_used;
        n_root_val   = r_root_val;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        link_rd_en   = 1'b0;
        link_rd_addr = {r_node, w_digit};
        link_wr_en   = 1'b0;
        link_wr_addr = {r_node, w_digit};
        link_wr_data = r_nodes_used[IDX_W-1:0];
        meta_rd_en   = 1'b0;
        meta_rd_addr = link_rd_data;
        meta_wr_en   = 1'b0;
        meta_wr_addr = r_node;
        meta_wr_data = '{parent: r_par, digit: r_dig, value: VALUE_EMPTY};

        // Drop the held result once the sink takes it.
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_rest  = i_in_data.key;
                    n_value = i_in_data.value;
                    n_node  = '0;
                    n_res   = '{result_value: VALUE_EMPTY, found: 1'b0, pool_full: 1'b0};
                end
            end
            S_LINK: begin
                link_rd_en = 1'b1;
            end
            S_META: begin
                meta_rd_en = 1'b1;
                n_child    = link_rd_data;
            end
            S_CHECK: begin
                if (w_link_ok) begin
                    // Advance one level.
                    n_par     = r_node;
                    n_dig     = w_digit;
                    n_node    = r_child;
                    n_cur_val = w_meta.value;
                    n_rest    = w_rest_next;
                end else begin
                    n_scan = r_rest;
                    n_need = '0;
                end
            end
            S_COUNT: begin
                if (r_scan != '0) begin
                    n_need = r_need + 1'b1;
                    n_scan = r_scan >> DIGIT_BITS;
                end
            end
            S_ROOM: begin
                if (!w_room) begin
                    n_res.pool_full = 1'b1;
                end
            end
            S_ALLOC: begin
                // Hang a fresh node on this slot; the last one takes the value.
                link_wr_en   = 1'b1;
                meta_wr_en   = 1'b1;
                meta_wr_addr = r_nodes_used[IDX_W-1:0];
                meta_wr_data = '{parent: r_node, digit: w_digit,
                                 value: w_last ? r_value : VALUE_EMPTY};
                n_nodes_used = r_nodes_used + 1'b1;
                n_node       = r_nodes_used[IDX_W-1:0];
                n_rest       = w_rest_next;
            end
            S_FINISH: begin
                if (r_cmd == CMD_FIND) begin
                    n_res.result_value = w_node_val;
                    n_res.found        = (w_node_val != VALUE_EMPTY);
                end else begin
                    if (r_node == '0) begin
                        n_root_val = (r_cmd == CMD_INSERT) ? r_value : VALUE_EMPTY;
                    end else begin
                        meta_wr_en   = 1'b1;
                        meta_wr_data = '{parent: r_par, digit: r_dig,
                                         value: (r_cmd == CMD_INSERT) ? r_value
                                                                      : VALUE_EMPTY};
                    end
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nodes_used <= CNT_W'(1);
            r_root_val   <= VALUE_EMPTY;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nodes_used <= n_nodes_used;
            r_root_val   <= n_root_val;
            r_out_valid  <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_rest     <= n_rest;
        r_scan     <= n_scan;
        r_value    <= n_value;
        r_node     <= n_node;
        r_par      <= n_par;
        r_dig      <= n_dig;
        r_cur_val  <= n_cur_val;
        r_child    <= n_child;
        r_need     <= n_need;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    `RTKV_ASSERT(a_pool_bound, i_clk, i_rst_n, r_nodes_used <= CNT_W'(NODE_COUNT))
    `RTKV_ASSERT_IMPL(a_alloc_room, i_clk, i_rst_n, r_state == S_ALLOC,
                      r_nodes_used < CNT_W'(NODE_COUNT))
    `RTKV_ASSERT_IMPL(a_grow_in_alloc, i_clk, i_rst_n,
                      r_nodes_used != $past(r_nodes_used), $past(r_state) == S_ALLOC)
    `RTKV_ASSERT_IMPL(a_found_value, i_clk, i_rst_n, o_out_valid && o_out_data.found,
                      (o_out_data.result_value != VALUE_EMPTY) && !o_out_data.pool_full)

endmodule

[rtl/rtkv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rtkv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
